// File: rtl/brfc_pkg.sv
// Shared types and constants of the bisection root finder for x^3 - x - 1.
package brfc_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned PREC_W = 31;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned KIND_W = 3;

  // Result beat kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ROW       = 3'd0,
    KIND_ROOT      = 3'd1,
    KIND_BAD_RANGE = 3'd2,
    KIND_A_ROOT    = 3'd3,
    KIND_B_ROOT    = 3'd4,
    KIND_NO_STEPS  = 3'd5
  } kind_e;

  // Which operand the cubic unit evaluates
  typedef enum logic [1:0] {
    EV_A,
    EV_B,
    EV_M
  } eval_sel_e;

  // Source of the midpoint / f_mid pair in a result beat
  typedef enum logic [1:0] {
    MID_ZERO,
    MID_A,
    MID_B,
    MID_M
  } mid_sel_e;

  // Source of step_index in a result beat
  typedef enum logic [1:0] {
    IDX_ZERO,
    IDX_STEP,
    IDX_TOTAL
  } idx_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      eval_go;
    eval_sel_e eval_sel;
    logic      take_int_steps;
    logic      search_init;
    logic      search_step;
    logic      take_search_steps;
    logic      first_step;
    logic      next_step;
    logic      mid;
    logic      update;
    logic      emit;
    kind_e     kind;
    mid_sel_e  mid_sel;
    idx_sel_e  idx_sel;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic eval_done;
    logic fa_zero;
    logic fb_zero;
    logic same_sign;
    logic frac_zero;
    logic search_stop;
    logic steps_zero;
    logic last_step;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/brfc_cubic.sv
// Four-stage pipelined evaluator of f(x) = x^3 - x - 1, saturated to 32 bits.
module brfc_cubic #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [brfc_pkg::DATA_W-1:0] x_i,
  output logic                             done_o,
  output logic signed [brfc_pkg::DATA_W-1:0] f_o
);
  import brfc_pkg::*;

  localparam int unsigned SQ_W = 64 - FRAC_BITS;
  localparam int unsigned C_W  = 65 - FRAC_BITS;
  localparam logic [C_W-1:0]  CAP_W  = C_W'(64'd1 << 34);
  localparam logic [34:0]     CAP    = 35'd1 << 34;
  localparam logic signed [37:0] ONE    = 38'sd1 <<< FRAC_BITS;
  localparam logic signed [37:0] SAT_HI = 38'sh00_7FFF_FFFF;
  localparam logic signed [37:0] SAT_LO = 38'sh3F_8000_0000;

  logic v0_q, v1_q, v2_q, v3_q;
  logic signed [DATA_W-1:0] x0_q, x1_q, x2_q;
  logic [DATA_W-1:0] ax0_q, ax1_q;
  logic [63:0] p1_q;
  logic [64:0] p2_q;
  logic big_q;
  logic signed [DATA_W-1:0] f_q;

  logic [DATA_W-1:0] ax;
  logic [SQ_W-1:0] sq;
  logic big;
  logic [C_W-1:0] shifted;
  logic [34:0] c;
  logic signed [35:0] cube;
  logic signed [37:0] total;
  logic signed [DATA_W-1:0] f_d;

  // magnitude; -2^31 maps to 2^31 as unsigned
  assign ax = x_i[DATA_W-1] ? (~x_i + 32'd1) : x_i;

  // square scaled back, overflow flag for the cap
  assign sq  = p1_q[63:FRAC_BITS];
  assign big = |sq[SQ_W-1:33];

  // cube magnitude with cap, sign, subtract x + 1, saturate
  always_comb begin
    shifted = p2_q[64:FRAC_BITS];
    if (big_q || (shifted > CAP_W)) begin
      c = CAP;
    end else begin
      c = shifted[34:0];
    end
    cube  = x2_q[DATA_W-1] ? -$signed({1'b0, c}) : $signed({1'b0, c});
    total = 38'(cube) - 38'(x2_q) - ONE;
    if (total > SAT_HI) begin
      f_d = 32'sh7FFF_FFFF;
    end else if (total < SAT_LO) begin
      f_d = 32'sh8000_0000;
    end else begin
      f_d = total[DATA_W-1:0];
    end
  end

  // stage valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= start_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x0_q  <= x_i;
      ax0_q <= ax;
    end
    x1_q  <= x0_q;
    ax1_q <= ax0_q;
    p1_q  <= ax0_q * ax0_q;
    x2_q  <= x1_q;
    big_q <= big;
    p2_q  <= sq[32:0] * ax1_q;
    f_q   <= f_d;
  end

  assign done_o = v3_q;
  assign f_o    = f_q;

endmodule

// File: rtl/brfc_dp.sv
// Datapath: interval, function values, step search and the result register.
module brfc_dp #(
  parameter int unsigned MAX_STEPS = 40,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  brfc_pkg::ctrl_cmd_t                cmd_i,
  output brfc_pkg::dp_status_t               status_o,
  input  logic signed [brfc_pkg::DATA_W-1:0] in_left_i,
  input  logic signed [brfc_pkg::DATA_W-1:0] in_right_i,
  input  logic [brfc_pkg::PREC_W-1:0]        in_prec_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output brfc_pkg::kind_e                    out_kind_o,
  output logic [brfc_pkg::IDX_W-1:0]         out_idx_o,
  output logic signed [brfc_pkg::DATA_W-1:0] out_left_o,
  output logic signed [brfc_pkg::DATA_W-1:0] out_right_o,
  output logic signed [brfc_pkg::DATA_W-1:0] out_fleft_o,
  output logic signed [brfc_pkg::DATA_W-1:0] out_fright_o,
  output logic signed [brfc_pkg::DATA_W-1:0] out_mid_o,
  output logic signed [brfc_pkg::DATA_W-1:0] out_fmid_o,
  output logic                               out_last_o
);
  import brfc_pkg::*;

  localparam int unsigned INT_W = PREC_W - FRAC_BITS;

  logic signed [DATA_W-1:0] a_q, b_q, fa_q, fb_q, m_q, fm_q;
  logic [PREC_W-1:0] prec_q;
  logic [32:0] diff_q;
  logic [33:0] p_q;
  logic [IDX_W-1:0] k_q, steps_q, i_q;
  eval_sel_e sel_q;

  logic signed [32:0] d, sum;
  logic [32:0] diff_d;
  logic [INT_W-1:0] prec_int;
  logic [IDX_W-1:0] int_steps;
  logic signed [DATA_W-1:0] eval_x, cub_f;
  logic cub_done, opp;

  logic valid_q, last_q;
  kind_e kind_q;
  logic [IDX_W-1:0] idx_q;
  logic signed [DATA_W-1:0] ol_q, or_q, ofl_q, ofr_q, om_q, ofm_q;
  logic signed [DATA_W-1:0] mid_src, fmid_src;
  logic [IDX_W-1:0] idx_src;

  // |b - a| for the tolerance search
  assign d      = 33'(in_right_i) - 33'(in_left_i);
  assign diff_d = d[32] ? 33'(-d) : 33'(d);

  // floor((a + b) / 2) without overflow
  assign sum = 33'(a_q) + 33'(b_q);

  // whole-number precision, clamped
  assign prec_int  = prec_q[PREC_W-1:FRAC_BITS];
  assign int_steps = (prec_int > INT_W'(MAX_STEPS)) ? IDX_W'(MAX_STEPS) : IDX_W'(prec_int);

  // b takes m when f(m) and f(a) are nonzero with opposite signs
  assign opp = (fm_q != '0) && (fa_q != '0) && (fm_q[DATA_W-1] != fa_q[DATA_W-1]);

  // cubic operand
  always_comb begin
    case (cmd_i.eval_sel)
      EV_A:    eval_x = a_q;
      EV_B:    eval_x = b_q;
      EV_M:    eval_x = m_q;
      default: eval_x = m_q;
    endcase
  end

  brfc_cubic #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cubic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.eval_go),
    .x_i    (eval_x),
    .done_o (cub_done),
    .f_o    (cub_f)
  );

  // interval, function values and counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= in_left_i;
      b_q    <= in_right_i;
      prec_q <= in_prec_i;
      diff_q <= diff_d;
    end
    if (cmd_i.eval_go) begin
      sel_q <= cmd_i.eval_sel;
    end
    if (cub_done) begin
      case (sel_q)
        EV_A:    fa_q <= cub_f;
        EV_B:    fb_q <= cub_f;
        EV_M:    fm_q <= cub_f;
        default: fm_q <= cub_f;
      endcase
    end
    if (cmd_i.search_init) begin
      p_q <= 34'(prec_q);
      k_q <= '0;
    end else if (cmd_i.search_step) begin
      p_q <= {p_q[32:0], 1'b0};
      k_q <= k_q + 1'b1;
    end
    if (cmd_i.take_int_steps) begin
      steps_q <= int_steps;
    end else if (cmd_i.take_search_steps) begin
      steps_q <= k_q;
    end
    if (cmd_i.first_step) begin
      i_q <= IDX_W'(1);
    end else if (cmd_i.next_step) begin
      i_q <= i_q + 1'b1;
    end
    if (cmd_i.mid) begin
      m_q <= sum[32:1];
    end
    if (cmd_i.update) begin
      if (opp) begin
        b_q  <= m_q;
        fb_q <= fm_q;
      end else begin
        a_q  <= m_q;
        fa_q <= fm_q;
      end
    end
  end

  // result beat sources
  always_comb begin
    case (cmd_i.mid_sel)
      MID_A: begin
        mid_src  = a_q;
        fmid_src = fa_q;
      end
      MID_B: begin
        mid_src  = b_q;
        fmid_src = fb_q;
      end
      MID_M: begin
        mid_src  = m_q;
        fmid_src = fm_q;
      end
      default: begin
        mid_src  = '0;
        fmid_src = '0;
      end
    endcase
    case (cmd_i.idx_sel)
      IDX_STEP:  idx_src = i_q;
      IDX_TOTAL: idx_src = steps_q;
      default:   idx_src = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q <= cmd_i.kind;
      idx_q  <= idx_src;
      ol_q   <= a_q;
      or_q   <= b_q;
      ofl_q  <= fa_q;
      ofr_q  <= fb_q;
      om_q   <= mid_src;
      ofm_q  <= fmid_src;
      last_q <= (cmd_i.kind != KIND_ROW);
    end
  end

  // status back to the controller
  assign status_o.eval_done   = cub_done;
  assign status_o.fa_zero     = (fa_q == '0);
  assign status_o.fb_zero     = (fb_q == '0);
  assign status_o.same_sign   = (fa_q != '0) && (fb_q != '0) &&
                                (fa_q[DATA_W-1] == fb_q[DATA_W-1]);
  assign status_o.frac_zero   = (prec_q[FRAC_BITS-1:0] == '0);
  assign status_o.search_stop = (k_q >= IDX_W'(MAX_STEPS)) || (p_q >= {1'b0, diff_q});
  assign status_o.steps_zero  = (steps_q == '0);
  assign status_o.last_step   = (i_q == steps_q);
  assign status_o.out_free    = !valid_q || out_ready_i;

  assign out_valid_o  = valid_q;
  assign out_kind_o   = kind_q;
  assign out_idx_o    = idx_q;
  assign out_left_o   = ol_q;
  assign out_right_o  = or_q;
  assign out_fleft_o  = ofl_q;
  assign out_fright_o = ofr_q;
  assign out_mid_o    = om_q;
  assign out_fmid_o   = ofm_q;
  assign out_last_o   = last_q;

endmodule

// File: rtl/brfc_ctrl.sv
// Controller: sequences the endpoint checks, step search and bisection steps.
module brfc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  brfc_pkg::dp_status_t status_i,
  output brfc_pkg::ctrl_cmd_t  cmd_o
);
  import brfc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL_A,
    S_WAIT_A,
    S_EVAL_B,
    S_WAIT_B,
    S_CHECK,
    S_SEARCH,
    S_STEPS,
    S_MID,
    S_EVAL_M,
    S_WAIT_M,
    S_ROW,
    S_FINAL,
    S_END
  } state_e;

  state_e state_q, state_d;
  kind_e  end_kind_q, end_kind_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and command decode
  always_comb begin
    state_d    = state_q;
    end_kind_d = end_kind_q;
    cmd_o      = '0;
    cmd_o.eval_sel = EV_M;
    cmd_o.kind     = KIND_ROW;
    cmd_o.mid_sel  = MID_ZERO;
    cmd_o.idx_sel  = IDX_ZERO;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL_A;
        end
      end
      S_EVAL_A: begin
        cmd_o.eval_go  = 1'b1;
        cmd_o.eval_sel = EV_A;
        state_d        = S_WAIT_A;
      end
      S_WAIT_A: begin
        if (status_i.eval_done) state_d = S_EVAL_B;
      end
      S_EVAL_B: begin
        cmd_o.eval_go  = 1'b1;
        cmd_o.eval_sel = EV_B;
        state_d        = S_WAIT_B;
      end
      S_WAIT_B: begin
        if (status_i.eval_done) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.same_sign) begin
          end_kind_d = KIND_BAD_RANGE;
          state_d    = S_END;
        end else if (status_i.fa_zero) begin
          end_kind_d = KIND_A_ROOT;
          state_d    = S_END;
        end else if (status_i.fb_zero) begin
          end_kind_d = KIND_B_ROOT;
          state_d    = S_END;
        end else if (status_i.frac_zero) begin
          cmd_o.take_int_steps = 1'b1;
          state_d              = S_STEPS;
        end else begin
          cmd_o.search_init = 1'b1;
          state_d           = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (status_i.search_stop) begin
          cmd_o.take_search_steps = 1'b1;
          state_d                 = S_STEPS;
        end else begin
          cmd_o.search_step = 1'b1;
        end
      end
      S_STEPS: begin
        if (status_i.steps_zero) begin
          end_kind_d = KIND_NO_STEPS;
          state_d    = S_END;
        end else begin
          cmd_o.first_step = 1'b1;
          state_d          = S_MID;
        end
      end
      S_MID: begin
        cmd_o.mid = 1'b1;
        state_d   = S_EVAL_M;
      end
      S_EVAL_M: begin
        cmd_o.eval_go  = 1'b1;
        cmd_o.eval_sel = EV_M;
        state_d        = S_WAIT_M;
      end
      S_WAIT_M: begin
        if (status_i.eval_done) state_d = S_ROW;
      end
      S_ROW: begin
        // row shows the interval before this step's update
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.kind    = KIND_ROW;
          cmd_o.mid_sel = MID_M;
          cmd_o.idx_sel = IDX_STEP;
          cmd_o.update  = 1'b1;
          if (status_i.last_step) begin
            state_d = S_FINAL;
          end else begin
            cmd_o.next_step = 1'b1;
            state_d         = S_MID;
          end
        end
      end
      S_FINAL: begin
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.kind    = KIND_ROOT;
          cmd_o.mid_sel = MID_M;
          cmd_o.idx_sel = IDX_TOTAL;
          state_d       = S_IDLE;
        end
      end
      S_END: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = end_kind_q;
          case (end_kind_q)
            KIND_A_ROOT: cmd_o.mid_sel = MID_A;
            KIND_B_ROOT: cmd_o.mid_sel = MID_B;
            default:     cmd_o.mid_sel = MID_ZERO;
          endcase
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      end_kind_q <= KIND_ROW;
    end else begin
      state_q    <= state_d;
      end_kind_q <= end_kind_d;
    end
  end

endmodule

// File: rtl/bisection_root_finder_cubic.sv
// Top level of the bisection root finder for x^3 - x - 1 in signed fixed point.
//
// One input beat carries an interval [a,b] and a precision; the block answers
// with one or more result beats, tlast on the final one. A precision with no
// fraction bits gives the step count directly, otherwise the step count is the
// smallest k with |b-a| <= precision*2^k; either way it is clamped to MAX_STEPS.
// The block works on one problem at a time: it accepts the beat, evaluates the
// two endpoints and checks them, runs the tolerance search one step at a time
// when the precision has fraction bits, checks the step count, then for each
// bisection step forms the midpoint, launches its evaluation, waits for the
// result and sends the row beat, and last sends the final beat. An endpoint
// check or a zero step count ends the run with a single beat instead. Each step
// waits once on the four-stage cubic evaluation pipeline, and a stalled output
// holds the run until the output register is free. The next input beat is taken
// as soon as the final result beat is in the output register.
module bisection_root_finder_cubic #(
  parameter int unsigned MAX_STEPS = 40,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] left_end, [63:32] right_end, [94:64] precision, [95] zero
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [5:0] step_index, [37:6] left_value, [69:38] right_value, [101:70] f_left,
  // [133:102] f_right, [165:134] midpoint, [197:166] f_mid, [199:198] zero
  output logic [199:0] m_axis_tdata,
  // [2:0] kind
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import brfc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  kind_e      out_kind;
  logic [IDX_W-1:0] out_idx;
  logic signed [DATA_W-1:0] out_left, out_right, out_fleft, out_fright, out_mid, out_fmid;

  brfc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  brfc_dp #(
    .MAX_STEPS(MAX_STEPS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_left_i   (s_axis_tdata[31:0]),
    .in_right_i  (s_axis_tdata[63:32]),
    .in_prec_i   (s_axis_tdata[94:64]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (out_kind),
    .out_idx_o   (out_idx),
    .out_left_o  (out_left),
    .out_right_o (out_right),
    .out_fleft_o (out_fleft),
    .out_fright_o(out_fright),
    .out_mid_o   (out_mid),
    .out_fmid_o  (out_fmid),
    .out_last_o  (m_axis_tlast)
  );

  // pack the result beat
  assign m_axis_tdata = {2'b00, out_fmid, out_mid, out_fright, out_fleft,
                         out_right, out_left, out_idx};
  assign m_axis_tuser = out_kind;

  // only the root/end kinds close a run
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser == KIND_ROW) != m_axis_tlast))
    else $error("tlast does not match result kind");

  // row beats carry a step number within range
  a_row_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_ROW)) |->
      ((m_axis_tdata[5:0] != 6'd0) && (32'(m_axis_tdata[5:0]) <= MAX_STEPS)))
    else $error("row beat with bad step index");

  // a new problem is not taken while one is in work
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted back to back");

endmodule
